// ===== rtl/core/stf_pkg.sv =====
// shared types, constants and helper functions for the servo tape feeder sequencer
package stf_pkg;

	localparam int ADVANCE_MM = 4;
	localparam int HALF_MM    = ADVANCE_MM / 2;

	localparam logic [7:0] ANGLE_MAX   = 8'd180;
	localparam logic [3:0] SAMPLE_DIV  = 4'd10;
	localparam logic [6:0] PRESS_MIN   = 7'd5;
	localparam logic [6:0] PRESS_MAX   = 7'd50;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_ADVANCE   = 3'd1,
		OP_ENABLE    = 3'd2,
		OP_DISABLE   = 3'd3,
		OP_POST_PICK = 3'd4,
		OP_GOTO      = 3'd5
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FULL_ANGLE    = 3'd0,
		CFG_HALF_ANGLE    = 3'd1,
		CFG_RETRACT_ANGLE = 3'd2,
		CFG_DEFAULT_FEED  = 3'd3,
		CFG_SETTLE_TIME   = 3'd4,
		CFG_IGNORE_ERROR  = 3'd5,
		CFG_HAS_FEEDBACK  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		POS_RETRACT = 2'd0,
		POS_HALF    = 2'd1,
		POS_FULL    = 2'd2
	} pos_t;

	typedef enum logic [3:0] {
		MODE_IDLE     = 4'b0001,
		MODE_MOVING   = 4'b0010,
		MODE_DONE     = 4'b0100,
		MODE_DISABLED = 4'b1000
	} mode_t;

	localparam logic [1:0] RUN_IDLE     = 2'd0;
	localparam logic [1:0] RUN_MOVING   = 2'd1;
	localparam logic [1:0] RUN_DONE     = 2'd2;
	localparam logic [1:0] RUN_DISABLED = 2'd3;

	localparam logic [1:0] ERR_NO_LINE = 2'd0;
	localparam logic [1:0] ERR_OK      = 2'd1;
	localparam logic [1:0] ERR_IGNORED = 2'd2;
	localparam logic [1:0] ERR_FAULT   = 2'd3;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] feed_request;
		logic       override;
		logic [7:0] target_angle;
		logic       feedback_level;
	} cmd_t;

	typedef struct packed {
		logic [7:0] servo_angle;
		logic       servo_on;
		logic       accepted;
		logic [1:0] error_state;
		logic [1:0] position;
		logic [1:0] run_state;
		logic       cycle_done;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  full_angle;
		logic [7:0]  half_angle;
		logic [7:0]  retract_angle_deg;
		logic [7:0]  default_feed;
		logic [15:0] settle_time;
		logic        ignore_error;
		logic        has_feedback;
	} cfg_t;

	function automatic logic [7:0] clamp_angle(input logic [7:0] a);
		return (a > ANGLE_MAX) ? ANGLE_MAX : a;
	endfunction

	function automatic logic [1:0] err_code(input cfg_t c, input logic level);
		logic [1:0] e;
		if (!c.has_feedback) begin
			e = ERR_NO_LINE;
		end else if (!level) begin
			e = ERR_OK;
		end else if (c.ignore_error) begin
			e = ERR_IGNORED;
		end else begin
			e = ERR_FAULT;
		end
		return e;
	endfunction

endpackage

// ===== rtl/core/stf_cfg.sv =====
// configuration register file for the feeder sequencer
module stf_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [stf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stf_pkg::CFG_DATA_W-1:0] cfg_data,
	output stf_pkg::cfg_t                  cfg
);
	import stf_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_angle        <= 8'd80;
			cfg_q.half_angle        <= 8'd50;
			cfg_q.retract_angle_deg <= 8'd25;
			cfg_q.default_feed      <= 8'd4;
			cfg_q.settle_time       <= 16'd240;
			cfg_q.ignore_error      <= 1'b0;
			cfg_q.has_feedback      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FULL_ANGLE:    cfg_q.full_angle        <= cfg_data[7:0];
				CFG_HALF_ANGLE:    cfg_q.half_angle        <= cfg_data[7:0];
				CFG_RETRACT_ANGLE: cfg_q.retract_angle_deg <= cfg_data[7:0];
				CFG_DEFAULT_FEED:  cfg_q.default_feed      <= cfg_data[7:0];
				CFG_SETTLE_TIME:   cfg_q.settle_time       <= cfg_data[15:0];
				CFG_IGNORE_ERROR:  cfg_q.ignore_error      <= cfg_data[0];
				CFG_HAS_FEEDBACK:  cfg_q.has_feedback      <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/stf_core.sv =====
// sequencer state registers and the single-pass next-state and result logic
module stf_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  stf_pkg::cmd_t  cmd,
	input  stf_pkg::cfg_t  cfg,
	output stf_pkg::rsp_t  rsp
);
	import stf_pkg::*;

	localparam logic [7:0] ADV  = 8'(ADVANCE_MM);
	localparam logic [7:0] HADV = 8'(HALF_MM);

	pos_t        pos_q, pos_n;
	mode_t       mode_q, mode_n;
	logic [7:0]  rem_q, rem_n;
	logic [15:0] settle_q, settle_n;
	logic [3:0]  sdiv_q, sdiv_n;
	logic [5:0]  press_q, press_n;
	logic        last_q, last_n;
	logic [7:0]  angle_q, angle_n;
	logic        drive_q, drive_n;
	logic [6:0]  press_t;
	logic [1:0]  err;
	logic        acc;
	logic        done;
	logic [1:0]  run_code;

	assign err = err_code(cfg, cmd.feedback_level);

	always_comb begin
		pos_n    = pos_q;
		mode_n   = mode_q;
		rem_n    = rem_q;
		settle_n = settle_q;
		sdiv_n   = sdiv_q;
		press_n  = press_q;
		last_n   = last_q;
		angle_n  = angle_q;
		drive_n  = drive_q;
		press_t  = {1'b0, press_q};
		acc      = 1'b1;
		done     = 1'b0;
		case (cmd.operation)
			OP_TICK: begin
				if (sdiv_q < SAMPLE_DIV) begin
					sdiv_n = sdiv_q + 4'd1;
				end
				if (settle_q != 16'hFFFF) begin
					settle_n = settle_q + 16'd1;
				end
				if (cfg.has_feedback) begin
					if (mode_q == MODE_IDLE) begin
						if (sdiv_n >= SAMPLE_DIV) begin
							sdiv_n = '0;
							if (press_q != '0) begin
								press_t = press_t + 7'd1;
							end
							if (cmd.feedback_level != last_q) begin
								last_n = cmd.feedback_level;
								if (!cmd.feedback_level) begin
									press_t = 7'd1;
								end
							end
							if (press_t > PRESS_MIN) begin
								if (cmd.feedback_level) begin
									if (cfg.default_feed != '0) begin
										rem_n = cfg.default_feed;
									end
									press_t = '0;
								end
								if (press_t > PRESS_MAX) begin
									press_t = '0;
								end
							end
							press_n = press_t[5:0];
						end
					end else begin
						last_n  = cmd.feedback_level;
						press_n = '0;
					end
				end
				if (settle_n >= cfg.settle_time) begin
					if (mode_n == MODE_DONE) begin
						drive_n = 1'b0;
						mode_n  = MODE_IDLE;
						done    = 1'b1;
					end
					if (rem_n == '0) begin
						if (mode_n != MODE_DISABLED) begin
							mode_n = MODE_IDLE;
						end
					end else begin
						mode_n = MODE_MOVING;
						case (pos_q)
							POS_RETRACT: begin
								if (rem_n >= ADV) begin
									drive_n  = 1'b1;
									angle_n  = clamp_angle(cfg.full_angle);
									pos_n    = POS_FULL;
									settle_n = '0;
									rem_n    = rem_n - ADV;
								end else if (rem_n >= HADV) begin
									drive_n  = 1'b1;
									angle_n  = clamp_angle(cfg.half_angle);
									pos_n    = POS_HALF;
									settle_n = '0;
									rem_n    = rem_n - HADV;
								end
							end
							POS_HALF: begin
								if (rem_n >= HADV) begin
									drive_n  = 1'b1;
									angle_n  = clamp_angle(cfg.full_angle);
									pos_n    = POS_FULL;
									settle_n = '0;
									rem_n    = rem_n - HADV;
								end
							end
							POS_FULL: begin
								drive_n  = 1'b1;
								angle_n  = clamp_angle(cfg.retract_angle_deg);
								pos_n    = POS_RETRACT;
								settle_n = '0;
							end
							default: ;
						endcase
						if (rem_n == '0) begin
							mode_n = MODE_DONE;
						end
					end
				end
			end
			OP_ADVANCE: begin
				if (err == ERR_FAULT && !cmd.override) begin
					acc = 1'b0;
				end else if (cmd.feed_request == '0) begin
					acc = 1'b1;
				end else if (mode_q != MODE_IDLE) begin
					acc = 1'b0;
				end else begin
					rem_n = cmd.feed_request;
				end
			end
			OP_ENABLE: begin
				mode_n = MODE_IDLE;
			end
			OP_DISABLE: begin
				mode_n  = MODE_DISABLED;
				drive_n = 1'b0;
			end
			OP_POST_PICK: begin
				if (pos_q == POS_FULL) begin
					drive_n  = 1'b1;
					angle_n  = clamp_angle(cfg.retract_angle_deg);
					pos_n    = POS_RETRACT;
					mode_n   = MODE_MOVING;
					settle_n = '0;
				end
			end
			OP_GOTO: begin
				drive_n = 1'b1;
				angle_n = clamp_angle(cmd.target_angle);
			end
			default: ;
		endcase
	end

	always_comb begin
		case (mode_n)
			MODE_IDLE:     run_code = RUN_IDLE;
			MODE_MOVING:   run_code = RUN_MOVING;
			MODE_DONE:     run_code = RUN_DONE;
			MODE_DISABLED: run_code = RUN_DISABLED;
			default:       run_code = RUN_IDLE;
		endcase
	end

	assign rsp.servo_angle = angle_n;
	assign rsp.servo_on    = drive_n;
	assign rsp.accepted    = acc;
	assign rsp.error_state = err;
	assign rsp.position    = pos_n;
	assign rsp.run_state   = run_code;
	assign rsp.cycle_done  = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_RETRACT;
			mode_q   <= MODE_IDLE;
			rem_q    <= '0;
			settle_q <= '0;
			sdiv_q   <= '0;
			press_q  <= '0;
			last_q   <= 1'b1;
			angle_q  <= '0;
			drive_q  <= 1'b0;
		end else if (en) begin
			pos_q    <= pos_n;
			mode_q   <= mode_n;
			rem_q    <= rem_n;
			settle_q <= settle_n;
			sdiv_q   <= sdiv_n;
			press_q  <= press_n;
			last_q   <= last_n;
			angle_q  <= angle_n;
			drive_q  <= drive_n;
		end
	end

endmodule

// ===== rtl/core/servo_tape_feeder_sequencer_top.sv =====
// top level of the servo tape feeder sequencer: request and result registers around the core
// a taken request waits in the request register, then its result is loaded into the result register
// throughput: one request per clock while results are taken; the request register frees as the result register moves
// a waiting result holds the request register: one more request is taken, then input stalls
// reset: arst_n clears all control state and loads the configuration defaults
// after reset the feeder is idle and retracted with the drive off
module servo_tape_feeder_sequencer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  stf_pkg::cmd_t                  cmd,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output stf_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [stf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import stf_pkg::*;

	cfg_t cfg;
	cmd_t cmd_s1;
	logic s1_valid_q;
	rsp_t rsp_next;
	rsp_t rsp_s2;
	logic s2_valid_q;
	logic fire;

	assign fire      = s1_valid_q && (!s2_valid_q || rsp_ready);
	assign cmd_ready = !s1_valid_q || fire;
	assign rsp_valid = s2_valid_q;
	assign rsp       = rsp_s2;

	stf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	stf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.rsp    (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= (cmd_valid && cmd_ready) || (s1_valid_q && !fire);
			s2_valid_q <= fire || (s2_valid_q && !rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
		if (fire) begin
			rsp_s2 <= rsp_next;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !fire) |-> !cmd_ready)
		else $error("request register overwritten before it was consumed");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.servo_angle <= ANGLE_MAX))
		else $error("commanded servo angle above range");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.cycle_done) |-> (rsp.run_state == RUN_IDLE && !rsp.servo_on))
		else $error("completed cycle did not return to idle with drive released");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("processed request produced no result");

endmodule
